@@ hdl/spdt_pkg.sv @@
// Shared types and constants of the switch position debounce and toggle unit.
`timescale 1ns / 1ps
`default_nettype none

package spdt_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEBOUNCE     = 2'd0,
		REG_SHORT_TOGGLE = 2'd1,
		REG_LONG_TOGGLE  = 2'd2
	} reg_index_t;

	localparam int CFG_W     = 16;
	localparam int SAMPLE_W  = 11;
	localparam int DELTA_W   = 8;
	localparam int POS_W     = 3;
	localparam int MASK_W    = 8;
	// (sample + full scale) * positions stays below 2^15 for every legal setting
	localparam int PROD_W    = 16;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd50;
	localparam logic [CFG_W-1:0] SHORT_TOGGLE_RST = 16'd100;
	localparam logic [CFG_W-1:0] LONG_TOGGLE_RST  = 16'd1000;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [MASK_W-1:0] mask_t;

endpackage

`default_nettype wire

@@ hdl/switch_position_debounce_toggle_unit.sv @@
// Top level of the switch position debounce and toggle unit.
//
//   channel   direction  beat contents
//   -------   ---------  --------------------------------------------------------
//   s_*       in         tdata: signal_value[10:0], delta_ms[18:11]; tuser: invalid
//   m_*       out        tdata: pos[2:0], momentary, short, long; tuser: valid
//   cfg_*     in         cfg_addr register index, cfg_data 16-bit value
//
// One tick per cycle while m is not stalled: the input register feeds a single pass of
// quantize, debounce and toggle logic that updates the switch state and loads the result
// register once that register is empty or being drained. A new beat is accepted every
// cycle while the result register drains.
// arst_n clears the valid flags and switch state and loads the register reset values.
// A stalled m side holds the result register and then the input register;
// s_tready falls only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module switch_position_debounce_toggle_unit #(
	parameter int CHANNELS   = 5,
	parameter int SIGNAL_MAX = 1000,
	parameter int TIME_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // signal_value[10:0], delta_ms[18:11], zero fill
	input  wire logic        s_tuser,   // signal_invalid[0]
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // debounced_pos[2:0], momentary_mask[10:3],
	                                    // short_mask[18:11], long_mask[26:19], zero fill
	output logic             m_tuser,   // debounced_valid[0]
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [15:0] cfg_data
);

	localparam int CMP_W = (TIME_WIDTH > spdt_pkg::CFG_W) ? TIME_WIDTH : spdt_pkg::CFG_W;
	localparam logic [TIME_WIDTH-1:0] TIME_SAT = {TIME_WIDTH{1'b1}};

	// ---------------------------------------------------------------- config
	logic [spdt_pkg::CFG_W-1:0] debounce_q, short_q, long_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= spdt_pkg::DEBOUNCE_RST;
			short_q    <= spdt_pkg::SHORT_TOGGLE_RST;
			long_q     <= spdt_pkg::LONG_TOGGLE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				spdt_pkg::REG_DEBOUNCE:     debounce_q <= cfg_data;
				spdt_pkg::REG_SHORT_TOGGLE: short_q    <= cfg_data;
				spdt_pkg::REG_LONG_TOGGLE:  long_q     <= cfg_data;
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// ---------------------------------------------------------- input register
	logic                                valid_s1;
	logic signed [spdt_pkg::SAMPLE_W-1:0] value_s1;
	logic                                invalid_s1;
	logic [spdt_pkg::DELTA_W-1:0]        delta_s1;
	logic                                advance;

	// the result register takes a new tick when empty or being drained
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			value_s1   <= s_tdata[10:0];
			delta_s1   <= s_tdata[18:11];
			invalid_s1 <= s_tuser;
		end
	end

	// ------------------------------------------------------------ switch state
	spdt_pkg::pos_t          raw_pos_q, stable_pos_q;
	logic                    raw_valid_q, stable_valid_q;
	logic [TIME_WIDTH-1:0]   raw_hold_q, stable_hold_q;
	spdt_pkg::mask_t         mom_q, short_flags_q, long_flags_q;

	// ---------------------------------------------------------------- quantize
	// position = count of thresholds k*2*SIGNAL_MAX that (sample+max)*CHANNELS reaches;
	// the top threshold caps it at CHANNELS-1
	logic signed [spdt_pkg::SAMPLE_W+1:0] num;
	logic [spdt_pkg::PROD_W-1:0]          prod;
	spdt_pkg::pos_t                       quant_pos;

	always_comb begin
		num       = (spdt_pkg::SAMPLE_W+2)'(value_s1) + (spdt_pkg::SAMPLE_W+2)'(SIGNAL_MAX);
		prod      = spdt_pkg::PROD_W'(num) * spdt_pkg::PROD_W'(CHANNELS);
		quant_pos = '0;
		if (num > 0) begin
			for (int k = 1; k < CHANNELS; k++) begin
				if (prod >= spdt_pkg::PROD_W'(k * 2 * SIGNAL_MAX)) begin
					quant_pos = spdt_pkg::POS_W'(k);
				end
			end
		end
	end

	// ----------------------------------------------------- debounce and toggle
	logic                  cur_valid, same, past, changed;
	spdt_pkg::pos_t        cur_pos, nd_pos;
	logic                  nd_valid;
	logic [TIME_WIDTH:0]   hold_sum;
	logic [TIME_WIDTH-1:0] raw_hold_nx, stable_hold_nx;
	spdt_pkg::mask_t       old_bit, new_bit, mom_nx, short_nx, long_nx;

	always_comb begin
		cur_valid = !invalid_s1;
		cur_pos   = cur_valid ? quant_pos : '0;
		same      = (cur_valid == raw_valid_q) && (!cur_valid || cur_pos == raw_pos_q);

		// saturating hold timer; restart on a new raw position
		hold_sum = {1'b0, raw_hold_q} + (TIME_WIDTH+1)'(delta_s1);
		if (!same) begin
			raw_hold_nx = '0;
		end else if (hold_sum[TIME_WIDTH]) begin
			raw_hold_nx = TIME_SAT;
		end else begin
			raw_hold_nx = hold_sum[TIME_WIDTH-1:0];
		end

		past     = same && (CMP_W'(raw_hold_nx) > CMP_W'(debounce_q));
		nd_valid = past ? raw_valid_q : stable_valid_q;
		nd_pos   = past ? raw_pos_q : stable_pos_q;
		changed  = (nd_valid != stable_valid_q) || (nd_valid && nd_pos != stable_pos_q);

		old_bit  = spdt_pkg::MASK_W'(1) << stable_pos_q;
		new_bit  = spdt_pkg::MASK_W'(1) << nd_pos;
		mom_nx   = mom_q;
		short_nx = short_flags_q;
		long_nx  = long_flags_q;
		if (changed) begin
			if (stable_valid_q) begin
				mom_nx = mom_nx & ~old_bit;
				// the position being left toggles by how long it was held
				if (CMP_W'(stable_hold_q) > CMP_W'(long_q)) begin
					long_nx = long_nx ^ old_bit;
				end else if (CMP_W'(stable_hold_q) > CMP_W'(short_q)) begin
					short_nx = short_nx ^ old_bit;
				end
			end
			if (nd_valid) begin
				mom_nx = mom_nx | new_bit;
			end
			stable_hold_nx = raw_hold_nx;
		end else begin
			stable_hold_nx = past ? raw_hold_nx : stable_hold_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_pos_q      <= '0;
			raw_valid_q    <= 1'b0;
			raw_hold_q     <= '0;
			stable_pos_q   <= '0;
			stable_valid_q <= 1'b0;
			stable_hold_q  <= '0;
			mom_q          <= '0;
			short_flags_q  <= '0;
			long_flags_q   <= '0;
		end else if (advance) begin
			raw_valid_q    <= cur_valid;
			raw_pos_q      <= cur_pos;
			raw_hold_q     <= raw_hold_nx;
			stable_valid_q <= nd_valid;
			stable_pos_q   <= nd_valid ? nd_pos : '0;
			stable_hold_q  <= stable_hold_nx;
			mom_q          <= mom_nx;
			short_flags_q  <= short_nx;
			long_flags_q   <= long_nx;
		end
	end

	// --------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tuser <= nd_valid;
			m_tdata <= {5'd0, long_nx, short_nx, mom_nx, (nd_valid ? nd_pos : 3'd0)};
		end
	end

	// -------------------------------------------------------------- assertions
	// the momentary mask marks exactly the debounced position
	a_mom_matches_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mom_q == (stable_valid_q ? (spdt_pkg::MASK_W'(1) << stable_pos_q) : '0))
		else $error("momentary mask out of step with debounced position");

	// an invalid debounced position reports position zero
	a_invalid_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!stable_valid_q |-> stable_pos_q == '0)
		else $error("invalid debounced position is not zero");

	// the debounced and raw positions stay within the switch positions
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stable_pos_q) < CHANNELS && 32'(raw_pos_q) < CHANNELS)
		else $error("switch position out of range");

	// at most one flag toggles per tick
	a_one_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		$countones((short_nx ^ short_flags_q) | (long_nx ^ long_flags_q)) <= 1)
		else $error("more than one toggle flag changed in one tick");

	// hold the switch state in any cycle that does not advance a tick
	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(stable_pos_q) && $stable(mom_q) && $stable(raw_hold_q))
		else $error("switch state moved without a tick");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the switch position debounce and toggle unit.
`timescale 1ns / 1ps

module testbench;

	localparam int CHANNELS        = 5;
	localparam int SIGNAL_MAX      = 1000;
	localparam int TIME_WIDTH      = 16;
	localparam int TIME_SAT        = (1 << TIME_WIDTH) - 1;
	localparam int HOLD_OFF_CYCLES = 60;
	// index past the last register: the block must ignore the write
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic            valid;
		spdt_pkg::pos_t  pos;
		spdt_pkg::mask_t momentary;
		spdt_pkg::mask_t short_tgl;
		spdt_pkg::mask_t long_tgl;
	} switch_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // signal_value[10:0], delta_ms[18:11], zero fill
	logic        s_tuser;   // signal_invalid[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // debounced_pos[2:0], momentary[10:3], short[18:11], long[26:19]
	logic        m_tuser;   // debounced_valid[0]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_data;

	// Shadow of the block: thresholds, raw and debounced switch state, flag masks
	int    thr_debounce, thr_short, thr_long;
	bit    raw_valid, deb_valid;
	int    raw_pos, deb_pos;
	int    raw_hold, deb_hold;
	spdt_pkg::mask_t momentary_flags, short_flags, long_flags;

	switch_result_t predicted_outputs[$];

	bit calm;            // set for the final stretch: no gaps, no stalls
	bit hold_off_req;    // asks the sink for one long stall
	int fail_count;
	int ticks_sent, results_checked, position_changes;
	int short_toggles, long_toggles, input_stall_cycles;

	switch_position_debounce_toggle_unit #(
		.CHANNELS  (CHANNELS),
		.SIGNAL_MAX(SIGNAL_MAX),
		.TIME_WIDTH(TIME_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Map a sample onto a switch position, clamping out-of-range values.
	function automatic int position_of(input logic signed [spdt_pkg::SAMPLE_W-1:0] sample);
		int num;
		int q;
		num = int'(sample) + SIGNAL_MAX;
		if (num <= 0)
			return 0;
		q = (num * CHANNELS) / (2 * SIGNAL_MAX);
		return (q > CHANNELS - 1) ? CHANNELS - 1 : q;
	endfunction

	// Random sample that quantizes to position p.
	function automatic int sample_in_position(input int p);
		int lo, hi;
		lo = (p == 0) ? -1024 : (2 * SIGNAL_MAX * p + CHANNELS - 1) / CHANNELS - SIGNAL_MAX;
		hi = (p == CHANNELS - 1) ? 1023
			: (2 * SIGNAL_MAX * (p + 1) + CHANNELS - 1) / CHANNELS - SIGNAL_MAX - 1;
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Advance the shadow state by one tick and queue the result it must produce.
	task automatic advance_switch(input logic signed [spdt_pkg::SAMPLE_W-1:0] sample,
			input logic invalid, input logic [spdt_pkg::DELTA_W-1:0] delta);
		switch_result_t r;
		bit now_valid, next_valid;
		int now_pos, next_pos, next_hold;
		now_valid  = !invalid;
		now_pos    = now_valid ? position_of(sample) : 0;
		next_valid = deb_valid;
		next_pos   = deb_pos;
		next_hold  = deb_hold;
		// two invalid samples count as the same position
		if (now_valid != raw_valid || (now_valid && now_pos != raw_pos)) begin
			raw_valid = now_valid;
			raw_pos   = now_pos;
			raw_hold  = 0;
		end else begin
			raw_hold = (raw_hold > TIME_SAT - int'(delta)) ? TIME_SAT : raw_hold + int'(delta);
			if (raw_hold > thr_debounce) begin
				next_valid = raw_valid;
				next_pos   = raw_pos;
				next_hold  = raw_hold;
			end
		end
		if (next_valid != deb_valid || (next_valid && next_pos != deb_pos)) begin
			position_changes++;
			// leaving a valid position: drop its momentary bit, toggle long over short
			if (deb_valid) begin
				momentary_flags[deb_pos] = 1'b0;
				if (deb_hold > thr_long) begin
					long_flags[deb_pos] = ~long_flags[deb_pos];
					long_toggles++;
				end else if (deb_hold > thr_short) begin
					short_flags[deb_pos] = ~short_flags[deb_pos];
					short_toggles++;
				end
			end
			if (next_valid)
				momentary_flags[next_pos] = 1'b1;
			deb_hold = raw_hold;
		end else begin
			deb_hold = next_hold;
		end
		deb_valid = next_valid;
		deb_pos   = next_valid ? next_pos : 0;

		r.valid     = deb_valid;
		r.pos       = spdt_pkg::pos_t'(deb_pos);
		r.momentary = momentary_flags;
		r.short_tgl = short_flags;
		r.long_tgl  = long_flags;
		predicted_outputs.push_back(r);
	endtask

	// Offer one tick, sometimes after a random gap, and hold it until accepted.
	task automatic send_tick(input int sample, input logic invalid, input int delta);
		logic signed [spdt_pkg::SAMPLE_W-1:0] smp;
		logic [spdt_pkg::DELTA_W-1:0] dly;
		int gap;
		smp = sample[spdt_pkg::SAMPLE_W-1:0];
		dly = delta[spdt_pkg::DELTA_W-1:0];
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {5'd0, dly, smp};
		s_tuser  = invalid;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		advance_switch(smp, invalid, dly);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic wait_drain();
		s_tvalid = 1'b0;
		while (predicted_outputs.size() != 0)
			@(negedge clk);
	endtask

	// Write one register; the block must be idle, so drain first.
	task automatic cfg_write(input logic [1:0] index,
			input logic [spdt_pkg::CFG_W-1:0] value);
		wait_drain();
		cfg_addr  = index;
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			spdt_pkg::REG_DEBOUNCE:     thr_debounce = int'(value);
			spdt_pkg::REG_SHORT_TOGGLE: thr_short    = int'(value);
			spdt_pkg::REG_LONG_TOGGLE:  thr_long     = int'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_thresholds(input int deb, input int shrt, input int lng);
		cfg_write(spdt_pkg::REG_DEBOUNCE, deb[spdt_pkg::CFG_W-1:0]);
		cfg_write(spdt_pkg::REG_SHORT_TOGGLE, shrt[spdt_pkg::CFG_W-1:0]);
		cfg_write(spdt_pkg::REG_LONG_TOGGLE, lng[spdt_pkg::CFG_W-1:0]);
	endtask

	// Mostly well-formed holds of one position with jittered samples, some noise.
	task automatic run_holds(input int count, input int max_delta, input int max_len);
		int sent, len, p, k;
		bit inv;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 6) == 0) begin
				send_tick($urandom_range(0, 2047), $urandom_range(0, 3) == 0,
					$urandom_range(0, 255));
				sent++;
			end else begin
				inv = ($urandom_range(0, 9) == 0);
				p   = $urandom_range(0, CHANNELS - 1);
				len = $urandom_range(1, max_len);
				for (k = 0; k < len; k++) begin
					send_tick(inv ? int'($urandom_range(0, 2047)) : sample_in_position(p), inv,
						$urandom_range(0, max_delta));
				end
				sent += len;
			end
		end
	endtask

	// Edges of the quantizer, invalid samples, and the toggle thresholds at reset values.
	task automatic test_directed_cases();
		repeat (3) send_tick(0, 1'b1, 255);          // invalid held: debounced as invalid
		repeat (2) send_tick(1023, 1'b0, 255);       // top of range clamps to the last position
		repeat (2) send_tick(-1024, 1'b0, 255);      // leave after 255 ms: short toggle
		send_tick(-1000, 1'b0, 0);
		send_tick(-1001, 1'b0, 0);
		send_tick(-600, 1'b0, 10);                   // first sample of position 1
		send_tick(-601, 1'b0, 10);                   // last sample of position 0
		repeat (5) send_tick(0, 1'b0, 255);          // long hold in the middle
		send_tick(999, 1'b0, 1);                     // one-tick glitch
		repeat (2) send_tick(0, 1'b0, 100);          // same position again, hold restarts
		repeat (2) send_tick(1023, 1'b0, 255);       // held exactly 100 ms: no toggle
		repeat (2) send_tick(-5, 1'b1, 255);         // leave to invalid: short toggle back
	endtask

	// Several threshold settings, the extremes among them, each with random holds.
	task automatic test_threshold_sweep();
		apply_thresholds(0, 0, 0);
		run_holds(50, 40, 6);
		apply_thresholds(65535, 65535, 65535);
		run_holds(40, 255, 10);
		apply_thresholds(20, 300, 600);
		run_holds(50, 255, 8);
		apply_thresholds(0, 65535, 0);
		run_holds(50, 255, 6);
		apply_thresholds(100, 0, 65535);
		cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
		run_holds(50, 255, 8);
		apply_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535));
		run_holds(40, 255, 10);
		apply_thresholds($urandom_range(0, 400), $urandom_range(0, 800),
			$urandom_range(500, 2000));
		run_holds(50, 255, 12);
		cfg_write(REG_UNUSED, 16'hffff);
		apply_thresholds(int'(spdt_pkg::DEBOUNCE_RST), int'(spdt_pkg::SHORT_TOGGLE_RST),
			int'(spdt_pkg::LONG_TOGGLE_RST));
		run_holds(50, 255, 10);
	endtask

	// Hold one position until the hold timer saturates, then leave it; again with the long threshold at its maximum.
	task automatic test_timer_saturation();
		int p, k;
		apply_thresholds(10, 100, 65534);
		p = $urandom_range(0, CHANNELS - 1);
		for (k = 0; k < 280; k++)
			send_tick(sample_in_position(p), 1'b0, $urandom_range(240, 255));
		repeat (3) send_tick(sample_in_position((p + 1) % CHANNELS), 1'b0, 200);
		cfg_write(spdt_pkg::REG_LONG_TOGGLE, 16'hffff);
		for (k = 0; k < 280; k++)
			send_tick(sample_in_position(p), 1'b0, $urandom_range(240, 255));
		repeat (3) send_tick(0, 1'b1, 200);
	endtask

	// Stall the result side for a long stretch while ticks keep coming.
	task automatic test_output_backpressure();
		hold_off_req = 1'b1;
		run_holds(50, 255, 6);
		wait (!hold_off_req);
	endtask

	// Pause the sender until the block has returned every result, then resume.
	task automatic test_sender_pause();
		run_holds(25, 255, 6);
		wait_drain();
		run_holds(25, 255, 6);
	endtask

	// Back-to-back ticks with the result side always ready.
	task automatic test_steady_stream();
		wait_drain();
		calm = 1'b1;
		apply_thresholds(30, 200, 700);
		run_holds(100, 255, 8);
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			fail_count++;
		end
	endtask

	// Compare each result beat with the oldest prediction.
	always @(posedge clk) begin : result_check
		switch_result_t want;
		if (arst_n && s_tvalid && !s_tready)
			input_stall_cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_outputs.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual tdata %0h tuser %0b",
					$time, m_tdata, m_tuser);
				fail_count++;
			end else begin
				want = predicted_outputs.pop_front();
				check_field("debounced_valid", int'(want.valid), int'(m_tuser));
				check_field("debounced_pos", int'(want.pos), int'(m_tdata[2:0]));
				check_field("momentary_mask", int'(want.momentary), int'(m_tdata[10:3]));
				check_field("short_mask", int'(want.short_tgl), int'(m_tdata[18:11]));
				check_field("long_mask", int'(want.long_tgl), int'(m_tdata[26:19]));
				check_field("tdata zero fill", 0, int'(m_tdata[31:27]));
				results_checked++;
			end
		end
	end

	// Result side: random stall bursts, one long hold-off on request, none when calm.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				m_tready = 1'b1;
				hold_off_req = 1'b0;
			end else if (calm) begin
				stall_left = 0;
				m_tready = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 10) - 1;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin : main_sequence
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_addr  = spdt_pkg::REG_DEBOUNCE;
		cfg_data  = '0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		fail_count = 0;
		ticks_sent = 0;
		results_checked = 0;
		position_changes = 0;
		short_toggles = 0;
		long_toggles = 0;
		input_stall_cycles = 0;

		// reset state of the shadow
		thr_debounce = int'(spdt_pkg::DEBOUNCE_RST);
		thr_short    = int'(spdt_pkg::SHORT_TOGGLE_RST);
		thr_long     = int'(spdt_pkg::LONG_TOGGLE_RST);
		raw_valid = 1'b0;
		raw_pos   = 0;
		raw_hold  = 0;
		deb_valid = 1'b0;
		deb_pos   = 0;
		deb_hold  = 0;
		momentary_flags = '0;
		short_flags     = '0;
		long_flags      = '0;

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_threshold_sweep();
		test_timer_saturation();
		test_output_backpressure();
		test_sender_pause();
		test_steady_stream();

		// let the pipeline settle past its last result
		wait_drain();
		repeat (10) @(negedge clk);

		$display("summary: %0d ticks, %0d results checked, %0d debounced position changes",
			ticks_sent, results_checked, position_changes);
		$display("summary: %0d short and %0d long toggles, input stalled %0d cycles",
			short_toggles, long_toggles, input_stall_cycles);
		if (fail_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
